### rtl/core/nfb_pkg.sv
// Shared constants, types and command format for the nibble framebuffer draw engine.
package nfb_pkg;

    // Screen geometry and store layout
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int ROW_BYTES     = (SCREEN_WIDTH + 1) / 2;
    localparam int STORE_DEPTH   = ROW_BYTES * SCREEN_HEIGHT;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int X_W    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int Y_W    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int B_W    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

    // Field widths
    localparam int ACT_W   = 3;
    localparam int COORD_W = 16;
    localparam int WIDE_W  = COORD_W + 1;
    localparam int COLOR_W = 4;
    localparam int THICK_W = 8;
    localparam int BYTE_W  = 2 * COLOR_W;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT   = 3'd0,
        ACT_GET   = 3'd1,
        ACT_HLINE = 3'd2,
        ACT_VLINE = 3'd3,
        ACT_BOX   = 3'd4,
        ACT_CLEAR = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        KIND_FILL  = 2'd0,
        KIND_GET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // One rectangle job, already clipped to the screen
    typedef struct packed {
        t_kind              kind;
        logic               draw;
        logic               clip;
        logic               last;
        logic [COLOR_W-1:0] color;
        logic [X_W-1:0]     xa;
        logic [X_W-1:0]     xe;
        logic [Y_W-1:0]     ya;
        logic [Y_W-1:0]     ye;
    } t_cmd;

    // Byte column that holds pixel x
    function automatic logic [B_W-1:0] byte_col(input logic [X_W-1:0] x);
        logic [X_W-1:0] half;
        half = x >> 1;
        return B_W'(half);
    endfunction

endpackage

### rtl/core/nibble_framebuffer_draw_engine.sv
// Top level of the 4-bit-per-pixel framebuffer draw engine.
// Put and get pass through the front, the queue and the back's load, read, write and done states;
// lines and boxes write a fully covered byte directly and read-merge a partly covered one.
// Clear walks the whole store at one byte per cycle.
// One word is split at a time; the walk over the frame store sets the throughput.
// After reset the store is zeroed by the same sweep; o_stall stays high until it ends.
module nibble_framebuffer_draw_engine import nfb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [COORD_W-1:0] i_x_start,
    input  logic [COORD_W-1:0] i_y_start,
    input  logic [COORD_W-1:0] i_x_end,
    input  logic [COORD_W-1:0] i_y_end,
    input  logic [COLOR_W-1:0] i_color,
    input  logic [THICK_W-1:0] i_thickness,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COLOR_W-1:0] o_pixel_value,
    output logic               o_clipped
);

    logic init_busy;
    logic q_full;
    logic q_empty;
    logic front_push;
    logic back_pop;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    // Accept and classify words
    nfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_color     (i_color),
        .i_thickness (i_thickness),
        .i_init      (init_busy),
        .i_full      (q_full),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    // Decouple front and back
    nfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty)
    );

    // Execute commands on the frame store
    nfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_cmd         (queue_cmd),
        .o_pop         (back_pop),
        .o_init        (init_busy),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_value (o_pixel_value),
        .o_clipped     (o_clipped)
    );

endmodule

### rtl/core/nfb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module nfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/nfb_queue.sv
// Short command queue between the front classifier and the back pixel walker.
module nfb_queue import nfb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed word
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/nfb_front.sv
// Front end: accepts draw words and splits them into clipped rectangle commands.
module nfb_front import nfb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [COORD_W-1:0] i_x_start,
    input  logic [COORD_W-1:0] i_y_start,
    input  logic [COORD_W-1:0] i_x_end,
    input  logic [COORD_W-1:0] i_y_end,
    input  logic [COLOR_W-1:0] i_color,
    input  logic [THICK_W-1:0] i_thickness,
    input  logic               i_init,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    // Box edges in issue order
    localparam logic [1:0] PART_TOP    = 2'd0;
    localparam logic [1:0] PART_BOTTOM = 2'd1;
    localparam logic [1:0] PART_LEFT   = 2'd2;
    localparam logic [1:0] PART_RIGHT  = 2'd3;

    logic               r_busy, n_busy;
    logic [1:0]         r_part, n_part;
    t_action            r_action;
    logic [COORD_W-1:0] r_xs, r_ys, r_xe, r_ye;
    logic [COLOR_W-1:0] r_color;
    logic [THICK_W-1:0] r_thick;

    logic [WIDE_W-1:0]  xs_w, ys_w, xe_w, ye_w, t_w, tm1_w;
    logic [WIDE_W-1:0]  xa, xb, ya, yb;
    logic               no_width;
    logic               empty;
    logic               off;
    logic               last;
    logic               push_ok;
    logic               done;
    logic               accept;

    assign xs_w  = WIDE_W'(r_xs);
    assign ys_w  = WIDE_W'(r_ys);
    assign xe_w  = WIDE_W'(r_xe);
    assign ye_w  = WIDE_W'(r_ye);
    assign t_w   = WIDE_W'(r_thick);
    assign tm1_w = t_w - 1'b1;

    // Select the rectangle of the current part
    always_comb begin
        xa       = xs_w;
        xb       = xs_w;
        ya       = ys_w;
        yb       = ys_w;
        no_width = (r_thick == '0);
        unique case (r_part)
            PART_TOP: begin
                xb = xe_w;
                yb = ys_w + tm1_w;
            end
            PART_BOTTOM: begin
                xb = xe_w;
                ya = ye_w;
                yb = ye_w + tm1_w;
            end
            PART_LEFT: begin
                xb = xs_w + tm1_w;
                yb = ye_w;
            end
            PART_RIGHT: begin
                xa = xe_w;
                xb = xe_w + tm1_w;
                yb = ye_w + t_w;
            end
            default: begin
            end
        endcase
        // A single pixel ignores thickness
        if (r_action == ACT_PUT || r_action == ACT_GET) begin
            xa       = xs_w;
            xb       = xs_w;
            ya       = ys_w;
            yb       = ys_w;
            no_width = 1'b0;
        end
    end

    // Classify and clip
    always_comb begin
        empty = no_width || (xa > xb) || (ya > yb);
        off   = (xa >= WIDE_W'(SCREEN_WIDTH)) || (ya >= WIDE_W'(SCREEN_HEIGHT));
        last  = (r_action != ACT_BOX) || (r_part == PART_RIGHT);

        o_cmd.color = r_color;
        o_cmd.last  = last;
        o_cmd.draw  = !empty && !off;
        o_cmd.clip  = !empty && ((xb >= WIDE_W'(SCREEN_WIDTH))
                                 || (yb >= WIDE_W'(SCREEN_HEIGHT)));
        o_cmd.xa    = X_W'(xa);
        o_cmd.ya    = Y_W'(ya);
        o_cmd.xe    = (xb >= WIDE_W'(SCREEN_WIDTH)) ? X_W'(SCREEN_WIDTH - 1) : X_W'(xb);
        o_cmd.ye    = (yb >= WIDE_W'(SCREEN_HEIGHT)) ? Y_W'(SCREEN_HEIGHT - 1) : Y_W'(yb);

        unique case (r_action)
            ACT_PUT, ACT_HLINE, ACT_VLINE, ACT_BOX: o_cmd.kind = KIND_FILL;
            ACT_GET:   o_cmd.kind = KIND_GET;
            ACT_CLEAR: o_cmd.kind = KIND_CLEAR;
            default:   o_cmd.kind = KIND_NONE;
        endcase
        if (o_cmd.kind == KIND_CLEAR || o_cmd.kind == KIND_NONE) begin
            o_cmd.draw = 1'b0;
            o_cmd.clip = 1'b0;
        end
    end

    // Handshake: take a new word as the last command of the old one leaves
    assign o_push  = r_busy;
    assign push_ok = r_busy && !i_full;
    assign done    = push_ok && last;
    assign o_stall = i_init || (r_busy && !done);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_busy = r_busy;
        n_part = r_part;
        if (push_ok) begin
            n_part = r_part + 1'b1;
        end
        if (done) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            n_busy = 1'b1;
            n_part = (t_action'(i_action) == ACT_VLINE) ? PART_LEFT : PART_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_part <= PART_TOP;
        end else begin
            r_busy <= n_busy;
            r_part <= n_part;
        end
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_action);
            r_xs     <= i_x_start;
            r_ys     <= i_y_start;
            r_xe     <= i_x_end;
            r_ye     <= i_y_end;
            r_color  <= i_color;
            r_thick  <= i_thickness;
        end
    end

endmodule

### rtl/core/nfb_back.sv
// Back end: walks rectangle commands over the frame store and returns results.
module nfb_back import nfb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_init,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COLOR_W-1:0] o_pixel_value,
    output logic               o_clipped
);

    typedef enum logic [5:0] {
        S_SWEEP = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOAD  = 6'b000100,
        S_RD    = 6'b001000,
        S_WR    = 6'b010000,
        S_DONE  = 6'b100000
    } t_bstate;

    t_bstate            r_state, n_state;
    logic               r_init, n_init;
    logic [ADDR_W-1:0]  r_sweep, n_sweep;
    t_cmd               r_cmd, n_cmd;
    logic [Y_W-1:0]     r_y, n_y;
    logic [B_W-1:0]     r_bx, n_bx;
    logic [ADDR_W-1:0]  r_row_base, n_row_base;
    logic [COLOR_W-1:0] r_pix, n_pix;
    logic               r_clip, n_clip;
    logic               r_out_valid, n_out_valid;
    logic [COLOR_W-1:0] r_out_pix, n_out_pix;
    logic               r_out_clip, n_out_clip;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic [BYTE_W-1:0]  ram_rdata;

    logic [B_W-1:0]     bx_first, bx_last;
    logic               hi_on, lo_on;
    logic               row_end, last_row;
    logic               out_free;
    logic               cmd_end;
    logic               step;

    nfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // Which nibbles of the current byte the rectangle covers
    assign bx_first = byte_col(r_cmd.xa);
    assign bx_last  = byte_col(r_cmd.xe);
    assign hi_on    = !((r_bx == bx_first) && r_cmd.xa[0]);
    assign lo_on    = !((r_bx == bx_last) && !r_cmd.xe[0]);
    assign row_end  = (r_bx == bx_last);
    assign last_row = (r_y == r_cmd.ye);

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_init   = r_init;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_sweep     = r_sweep;
        n_cmd       = r_cmd;
        n_y         = r_y;
        n_bx        = r_bx;
        n_row_base  = r_row_base;
        n_pix       = r_pix;
        n_clip      = r_clip;
        n_out_valid = r_out_valid && i_stall;
        n_out_pix   = r_out_pix;
        n_out_clip  = r_out_clip;
        ram_we      = 1'b0;
        ram_addr    = r_row_base + ADDR_W'(r_bx);
        ram_wdata   = {r_cmd.color, r_cmd.color};
        cmd_end     = 1'b0;
        step        = 1'b0;

        unique case (r_state)
            // Zero the store one byte per cycle
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_addr  = r_sweep;
                ram_wdata = '0;
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_sweep = '0;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        cmd_end = 1'b1;
                    end
                end
            end

            // Pop the next command and dispatch on its kind
            S_IDLE: begin
                if (!i_empty) begin
                    n_cmd  = i_cmd;
                    n_y    = i_cmd.ya;
                    n_bx   = byte_col(i_cmd.xa);
                    n_clip = r_clip | i_cmd.clip;
                    unique case (i_cmd.kind)
                        KIND_FILL, KIND_GET: begin
                            n_state = i_cmd.draw ? S_LOAD
                                    : (i_cmd.last ? S_DONE : S_IDLE);
                        end
                        KIND_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = i_cmd.last ? S_DONE : S_IDLE;
                        end
                    endcase
                end
            end

            // Form the first row address
            S_LOAD: begin
                n_row_base = ADDR_W'(r_y) * ADDR_W'(ROW_BYTES);
                n_state    = S_RD;
            end

            // Write a fully covered byte, else read it for merging or for get
            S_RD: begin
                if (r_cmd.kind == KIND_FILL && hi_on && lo_on) begin
                    ram_we = 1'b1;
                    step   = 1'b1;
                end else begin
                    n_state = S_WR;
                end
            end

            // Merge a nibble into the read byte, or return it for get
            S_WR: begin
                if (r_cmd.kind == KIND_GET) begin
                    n_pix   = r_cmd.xa[0] ? ram_rdata[COLOR_W-1:0]
                                          : ram_rdata[BYTE_W-1:COLOR_W];
                    cmd_end = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = {hi_on ? r_cmd.color : ram_rdata[BYTE_W-1:COLOR_W],
                                 lo_on ? r_cmd.color : ram_rdata[COLOR_W-1:0]};
                    step      = 1'b1;
                end
            end

            // Hand the result to the output register
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_pix;
                    n_out_clip  = r_clip;
                    n_pix       = '0;
                    n_clip      = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance to the next byte or row
        if (step) begin
            if (!row_end) begin
                n_bx    = r_bx + 1'b1;
                n_state = S_RD;
            end else if (!last_row) begin
                n_y        = r_y + 1'b1;
                n_bx       = bx_first;
                n_row_base = r_row_base + ADDR_W'(ROW_BYTES);
                n_state    = S_RD;
            end else begin
                cmd_end = 1'b1;
            end
        end

        if (cmd_end) begin
            n_state = r_cmd.last ? S_DONE : S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_pix       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_sweep     <= n_sweep;
            r_pix       <= n_pix;
            r_clip      <= n_clip;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold command, walk position and output data
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_y        <= n_y;
        r_bx       <= n_bx;
        r_row_base <= n_row_base;
        r_out_pix  <= n_out_pix;
        r_out_clip <= n_out_clip;
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_out_pix;
    assign o_clipped     = r_out_clip;

endmodule

### sim/testbench.sv
// Self-checking testbench for the nibble framebuffer draw engine.
`timescale 1ns / 1ps

module testbench;
    import nfb_pkg::*;

    // Codes past the last real action: the engine must draw nothing for them but still reply
    localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

    localparam int RANDOM_CMDS = 1030;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 200;
    localparam longint WATCHDOG_NS = 64'd48_000_000;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [COLOR_W-1:0] color;
        logic [THICK_W-1:0] thickness;
    } draw_cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic               clipped;
    } pixel_reply_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [ACT_W-1:0]   i_action = '0;
    logic [COORD_W-1:0] i_x_start = '0;
    logic [COORD_W-1:0] i_y_start = '0;
    logic [COORD_W-1:0] i_x_end = '0;
    logic [COORD_W-1:0] i_y_end = '0;
    logic [COLOR_W-1:0] i_color = '0;
    logic [THICK_W-1:0] i_thickness = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [COLOR_W-1:0] o_pixel_value;
    logic               o_clipped;

    draw_cmd_t    draw_cmds[$];
    pixel_reply_t expected_replies[$];
    draw_cmd_t    cur_cmd;
    logic [BYTE_W-1:0] frame_mem [STORE_DEPTH];

    int total_cmds = 1;
    int accepted_cmds = 0;
    int error_count = 0;
    logic [COORD_W-1:0] last_x = '0;
    logic [COORD_W-1:0] last_y = '0;

    nibble_framebuffer_draw_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_color       (i_color),
        .i_thickness   (i_thickness),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_value (o_pixel_value),
        .o_clipped     (o_clipped)
    );

    always #4 i_clk = ~i_clk;

    // Frame store shadow: even x in the high nibble, odd x in the low one
    function automatic void poke_pixel(int unsigned x, int unsigned y,
                                       logic [COLOR_W-1:0] c);
        int unsigned idx;
        idx = y * ROW_BYTES + (x >> 1);
        if (x[0]) begin
            frame_mem[idx][COLOR_W-1:0] = c;
        end else begin
            frame_mem[idx][BYTE_W-1:COLOR_W] = c;
        end
    endfunction

    function automatic logic [COLOR_W-1:0] peek_pixel(int unsigned x, int unsigned y);
        int unsigned idx;
        idx = y * ROW_BYTES + (x >> 1);
        return x[0] ? frame_mem[idx][COLOR_W-1:0] : frame_mem[idx][BYTE_W-1:COLOR_W];
    endfunction

    // Fill an inclusive rectangle, trimmed to the screen; report any overhang
    function automatic bit fill_area(int unsigned xa, int unsigned xb, int unsigned ya,
                                     int unsigned yb, logic [COLOR_W-1:0] c);
        bit overhang;
        int unsigned xl, yl;
        if (xa > xb || ya > yb) return 1'b0;
        overhang = (xb >= SCREEN_WIDTH) || (yb >= SCREEN_HEIGHT);
        if (xa >= SCREEN_WIDTH || ya >= SCREEN_HEIGHT) return 1'b1;
        xl = (xb >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : xb;
        yl = (yb >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1 : yb;
        for (int unsigned y = ya; y <= yl; y++) begin
            for (int unsigned x = xa; x <= xl; x++) begin
                poke_pixel(x, y, c);
            end
        end
        return overhang;
    endfunction

    function automatic bit paint_hband(int unsigned x0, int unsigned x1, int unsigned y0,
                                       int unsigned t, logic [COLOR_W-1:0] c);
        if (t == 0) return 1'b0;
        return fill_area(x0, x1, y0, y0 + t - 1, c);
    endfunction

    function automatic bit paint_vband(int unsigned y0, int unsigned y1, int unsigned x0,
                                       int unsigned t, logic [COLOR_W-1:0] c);
        if (t == 0) return 1'b0;
        return fill_area(x0, x0 + t - 1, y0, y1, c);
    endfunction

    // Update the shadow store for one accepted word and queue its reply
    function automatic void apply_command(draw_cmd_t c);
        pixel_reply_t r;
        bit on_screen;
        int unsigned xs, ys, xe, ye, t;
        r = '0;
        xs = c.x_start;
        ys = c.y_start;
        xe = c.x_end;
        ye = c.y_end;
        t = c.thickness;
        on_screen = (xs < SCREEN_WIDTH) && (ys < SCREEN_HEIGHT);
        case (c.action)
            ACT_PUT: begin
                if (on_screen) poke_pixel(xs, ys, c.color);
                else r.clipped = 1'b1;
            end
            ACT_GET: begin
                if (on_screen) r.pixel = peek_pixel(xs, ys);
                else r.clipped = 1'b1;
            end
            ACT_HLINE: r.clipped = paint_hband(xs, xe, ys, t, c.color);
            ACT_VLINE: r.clipped = paint_vband(ys, ye, xs, t, c.color);
            ACT_BOX: begin
                r.clipped = paint_hband(xs, xe, ys, t, c.color);
                r.clipped = paint_hband(xs, xe, ye, t, c.color) | r.clipped;
                r.clipped = paint_vband(ys, ye, xs, t, c.color) | r.clipped;
                // right edge reaches one thickness past the bottom
                r.clipped = paint_vband(ys, ye + t, xe, t, c.color) | r.clipped;
            end
            ACT_CLEAR: begin
                foreach (frame_mem[i]) frame_mem[i] = '0;
            end
            default: ;
        endcase
        expected_replies.push_back(r);
    endfunction

    // Idle and stall odds by phase: none, sender, receiver, both lightly
    function automatic int unsigned idle_pct(bit rx_side);
        case ((accepted_cmds * 8 / total_cmds) % 4)
            1: return rx_side ? 0 : 54;
            2: return rx_side ? 54 : 0;
            3: return 7;
            default: return 0;
        endcase
    endfunction

    task automatic add_cmd(logic [ACT_W-1:0] act, int unsigned xs, int unsigned ys,
                           int unsigned xe, int unsigned ye, int unsigned c,
                           int unsigned t);
        draw_cmd_t d;
        d.action = act;
        d.x_start = COORD_W'(xs);
        d.y_start = COORD_W'(ys);
        d.x_end = COORD_W'(xe);
        d.y_end = COORD_W'(ye);
        d.color = COLOR_W'(c);
        d.thickness = THICK_W'(t);
        draw_cmds.push_back(d);
    endtask

    // Coordinates lean on a small corner so that gets hit drawn pixels
    function automatic int unsigned pick_coord(int unsigned limit, int unsigned hot);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, hot);
            4, 5, 6: return $urandom_range(0, limit - 1);
            7: return $urandom_range(limit - 4, limit + 3);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int unsigned pick_end(int unsigned s, bit narrow);
        if (narrow) return (s + $urandom_range(0, 3)) & 16'hFFFF;
        case ($urandom_range(0, 9))
            7: return (s - $urandom_range(1, 40)) & 16'hFFFF;
            8, 9: return $urandom_range(0, 65535);
            default: return (s + $urandom_range(0, 24)) & 16'hFFFF;
        endcase
    endfunction

    task automatic add_random_cmd();
        int unsigned sel, xs, ys, xe, ye, t;
        bit wide;
        logic [ACT_W-1:0] act;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 299) == 0) act = ACT_CLEAR;
        else if (sel < 25) act = ACT_PUT;
        else if (sel < 45) act = ACT_GET;
        else if (sel < 60) act = ACT_HLINE;
        else if (sel < 75) act = ACT_VLINE;
        else if (sel < 92) act = ACT_BOX;
        else act = sel[0] ? ACT_SPARE_A : ACT_SPARE_B;

        // mostly thin lines; the thickest ones keep short spans to bound the walk
        sel = $urandom_range(0, 99);
        wide = 1'b0;
        if (sel < 85) begin
            t = $urandom_range(0, 4);
        end else if (sel < 95) begin
            t = $urandom_range(5, 16);
        end else begin
            t = $urandom_range(128, 255);
            wide = 1'b1;
        end

        xs = pick_coord(SCREEN_WIDTH, 23);
        ys = pick_coord(SCREEN_HEIGHT, 11);
        if (act == ACT_BOX && wide) xs = $urandom_range(SCREEN_WIDTH - 30, SCREEN_WIDTH + 10);
        if (act == ACT_GET && $urandom_range(0, 1)) begin
            xs = last_x;
            ys = last_y;
        end
        xe = pick_end(xs, wide);
        ye = pick_end(ys, wide);
        if (act == ACT_PUT || act == ACT_HLINE || act == ACT_VLINE) begin
            last_x = COORD_W'(xs);
            last_y = COORD_W'(ys);
        end
        add_cmd(act, xs, ys, xe, ye, $urandom_range(0, 15), t);
    endtask

    // Driver: present the next word, hold it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_command(cur_cmd);
                accepted_cmds++;
            end
            if (!i_valid || !o_stall) begin
                if (draw_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    cur_cmd = draw_cmds.pop_front();
                    i_valid <= 1'b1;
                    i_action <= cur_cmd.action;
                    i_x_start <= cur_cmd.x_start;
                    i_y_start <= cur_cmd.y_start;
                    i_x_end <= cur_cmd.x_end;
                    i_y_end <= cur_cmd.y_end;
                    i_color <= cur_cmd.color;
                    i_thickness <= cur_cmd.thickness;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(string field, int unsigned exp_val, int unsigned act_val);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field,
                     exp_val, act_val);
    endtask

    // Monitor: compare each accepted reply with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_replies.size() == 0) begin
                    note_mismatch("unexpected reply, pixel", 0, o_pixel_value);
                end else begin
                    pixel_reply_t r;
                    r = expected_replies.pop_front();
                    if (o_pixel_value !== r.pixel)
                        note_mismatch("pixel_value", r.pixel, o_pixel_value);
                    if (o_clipped !== r.clipped)
                        note_mismatch("clipped", r.clipped, o_clipped);
                end
            end
            i_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
        end
    end

    initial begin
        foreach (frame_mem[i]) frame_mem[i] = '0;

        // Directed: nibble order, screen corners, clipping, empty and overflowing spans
        add_cmd(ACT_GET, 0, 0, 0, 0, 0, 0);
        add_cmd(ACT_PUT, 0, 0, 0, 0, 15, 0);
        add_cmd(ACT_PUT, 1, 0, 0, 0, 5, 0);
        add_cmd(ACT_GET, 0, 0, 0, 0, 0, 0);
        add_cmd(ACT_GET, 1, 0, 0, 0, 0, 0);
        add_cmd(ACT_PUT, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 10, 0);
        add_cmd(ACT_GET, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 0, 0);
        add_cmd(ACT_PUT, SCREEN_WIDTH, 0, 0, 0, 15, 0);
        add_cmd(ACT_GET, 0, SCREEN_HEIGHT, 0, 0, 0, 0);
        add_cmd(ACT_PUT, 65535, 65535, 65535, 65535, 15, 255);
        add_cmd(ACT_HLINE, 2, 3, 9, 0, 3, 2);
        add_cmd(ACT_GET, 5, 4, 0, 0, 0, 0);
        add_cmd(ACT_HLINE, 0, 0, 9, 0, 9, 0);
        add_cmd(ACT_HLINE, 9, 0, 2, 0, 9, 1);
        add_cmd(ACT_HLINE, 0, 65535, 3, 0, 1, 255);
        add_cmd(ACT_HLINE, 40, 0, 41, 0, 12, 255);
        add_cmd(ACT_VLINE, SCREEN_WIDTH - 2, 10, 0, 20, 6, 4);
        add_cmd(ACT_VLINE, 0, 20, 0, 10, 6, 3);
        add_cmd(ACT_BOX, 20, 20, 30, 28, 7, 1);
        add_cmd(ACT_GET, 30, 29, 0, 0, 0, 0);
        add_cmd(ACT_GET, 20, 29, 0, 0, 0, 0);
        add_cmd(ACT_BOX, 50, 50, 60, 65535, 2, 1);
        add_cmd(ACT_SPARE_A, 65535, 65535, 65535, 65535, 15, 255);
        add_cmd(ACT_SPARE_B, 65535, 65535, 65535, 65535, 15, 255);
        add_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
        add_cmd(ACT_GET, 30, 29, 0, 0, 0, 0);

        for (int i = 0; i < RANDOM_CMDS; i++) add_random_cmd();
        total_cmds = draw_cmds.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in and every reply to come back
        while (draw_cmds.size() != 0 || i_valid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
